// File: src/edf_pkg.sv
package edf_pkg;

   localparam int SLOTS     = 32;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int CPU_COUNT = 16;
   localparam int TASK_W    = 22;
   localparam int CPU_W     = 4;
   localparam int TIME_W    = 64;
   localparam int PRIO_W    = 7;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_EXPIRE = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_CPU   = 3'd1;
   localparam logic [2:0] ST_BAD_TIMES = 3'd2;
   localparam logic [2:0] ST_PRESENT   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   localparam logic CSR_NUM_CPUS = 1'b0;
   localparam logic CSR_TOP_PRIO = 1'b1;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic [2:0]        status;
      logic [TASK_W-1:0] task_id;
      logic [CPU_W-1:0]  cpu_id;
      logic [PRIO_W-1:0] prio;
      logic              last;
   } result_type;

endpackage

// File: src/edf_partitioned_priority_table.sv
// EDF priority table. Holds up to SLOTS reservations in a slot memory. Each
// event is handled by a sequencer around one shared 64-bit compare/add unit
// that sees one slot read per cycle while no slot write is pending: a lookup
// sweep over the slots, then for a successful event a ranking pass that, for
// each cpu in turn and each rank, sweeps all slots to find the next-earliest
// deadline. An error result is pushed once the lookup is done and the output
// register is free. The sequencer waits while the output register is stalled
// with a result in it. The block takes no new event until the last result of
// the current one has been pushed into the output register.
module edf_partitioned_priority_table
   import edf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic [TASK_W-1:0]   req_task_id,
   input  logic [7:0]          req_cpu_id,
   input  logic [TIME_W-1:0]   req_budget_ns,
   input  logic [TIME_W-1:0]   req_deadline_ns,
   input  logic [TIME_W-1:0]   req_now_ns,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [TASK_W-1:0]   rsp_out_task_id,
   output logic [CPU_W-1:0]    rsp_out_cpu_id,
   output logic [PRIO_W-1:0]   rsp_priority_res,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [6:0]          csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_DECIDE, S_SCAN, S_PICK, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]        num_cpus_ff, num_cpus_in;
   logic [PRIO_W-1:0] top_ff, top_in;

   // request latch
   logic [1:0]        kind_ff, kind_in;
   logic [TASK_W-1:0] task_ff, task_in;
   logic [7:0]        cpu_ff, cpu_in;
   logic [TIME_W-1:0] budget_ff, dl_ff, now_ff;
   logic [TIME_W-1:0] budget_in, dl_in, now_in;

   // slot state
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [TASK_W-1:0] mem_task [SLOTS];
   logic [CPU_W-1:0]  mem_cpu  [SLOTS];
   logic [TIME_W-1:0] mem_rel  [SLOTS];
   logic [TIME_W-1:0] mem_abs  [SLOTS];

   // sequencer registers
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [CPU_W-1:0]  cur_cpu_ff, cur_cpu_in;
   logic [CNT_W-1:0]  rank_ff, rank_in;
   logic [SLOTS-1:0]  done_ff, done_in;     // slots already emitted
   logic              best_ok_ff, best_ok_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] best_abs_ff, best_abs_in;
   logic              any_ff, any_in;
   result_type        pend_ff, pend_in;     // result held back for the last mark

   // registered read of the slot memory
   logic [TASK_W-1:0] rd_task_ff;
   logic [CPU_W-1:0]  rd_cpu_ff;
   logic [TIME_W-1:0] rd_rel_ff, rd_abs_ff;
   logic              rd_v_ff, rd_v_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;

   // slot memory write port
   logic              mem_we_ff, mem_we_in;
   logic [SLOT_W-1:0] mem_wa_ff, mem_wa_in;
   logic              wr_all_ff, wr_all_in;
   logic [TIME_W-1:0] wr_abs_ff, wr_abs_in;

   logic [SLOT_W-1:0] idx_s;
   assign idx_s = idx_ff[SLOT_W-1:0];

   logic       push_ff, push_in;
   result_type push_data_ff, push_data_in;
   logic       oreg_empty;
   result_type rsp_data;

   edf_out_reg u_out (
      .clock, .reset, .push(push_ff), .push_data(push_data_ff), .empty(oreg_empty),
      .rsp_valid, .rsp_stall, .rsp_data
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_out_task_id  = rsp_data.task_id;
   assign rsp_out_cpu_id   = rsp_data.cpu_id;
   assign rsp_priority_res = rsp_data.prio;
   assign rsp_last         = rsp_data.last;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // shared compare/add unit
   logic [TIME_W-1:0] sum_a, sum_b, sum;
   logic              lt;
   always_comb begin
      sum_a = now_ff;
      sum_b = (kind_ff == KIND_ADD) ? dl_ff : rd_rel_ff;
      sum   = sum_a + sum_b;
      lt    = rd_abs_ff < best_abs_ff;
   end

   // error checks for add
   logic [4:0] ncpu;
   logic       bad_cpu, bad_times;
   always_comb begin
      ncpu      = (num_cpus_ff > 5'(CPU_COUNT)) ? 5'(CPU_COUNT) : num_cpus_ff;
      bad_cpu   = {1'b0, cpu_ff} >= {4'd0, ncpu};
      bad_times = (budget_ff == '0) || (dl_ff == '0) || (dl_ff < budget_ff);
   end

   logic [PRIO_W-1:0] prio_val;
   always_comb begin
      if ({1'b0, top_ff} >= 8'(rank_ff)) begin
         prio_val = PRIO_W'({1'b0, top_ff} - 8'(rank_ff));
      end else begin
         prio_val = '0;
      end
   end

   // slot memory: one registered read and one write per cycle
   always_ff @(posedge clock) begin
      rd_task_ff <= mem_task[idx_s];
      rd_cpu_ff  <= mem_cpu[idx_s];
      rd_rel_ff  <= mem_rel[idx_s];
      rd_abs_ff  <= mem_abs[idx_s];
      if (mem_we_ff) begin
         mem_abs[mem_wa_ff] <= wr_abs_ff;
         if (wr_all_ff) begin
            mem_task[mem_wa_ff] <= task_ff;
            mem_cpu[mem_wa_ff]  <= cpu_ff[CPU_W-1:0];
            mem_rel[mem_wa_ff]  <= dl_ff;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      num_cpus_in  = num_cpus_ff;
      top_in       = top_ff;
      kind_in      = kind_ff;
      task_in      = task_ff;
      cpu_in       = cpu_ff;
      budget_in    = budget_ff;
      dl_in        = dl_ff;
      now_in       = now_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      cur_cpu_in   = cur_cpu_ff;
      rank_in      = rank_ff;
      done_in      = done_ff;
      best_ok_in   = best_ok_ff;
      best_in      = best_ff;
      best_abs_in  = best_abs_ff;
      any_in       = any_ff;
      pend_in      = pend_ff;
      rd_v_in      = 1'b0;
      rd_slot_in   = rd_slot_ff;
      mem_we_in    = 1'b0;
      mem_wa_in    = mem_wa_ff;
      wr_all_in    = 1'b0;
      wr_abs_in    = wr_abs_ff;
      push_in      = 1'b0;
      push_data_in = push_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_CPUS: num_cpus_in = csr_wdata[4:0];
            CSR_TOP_PRIO: top_in      = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_kind != KIND_UNUSED) begin
               kind_in   = req_kind;
               task_in   = req_task_id;
               cpu_in    = req_cpu_id;
               budget_in = req_budget_ns;
               dl_in     = req_deadline_ns;
               now_in    = req_now_ns;
               idx_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = S_FIND;
            end
         end
         S_FIND: begin
            // one slot read per cycle, evaluated from the registered read data
            if (rd_v_ff && valid_ff[rd_slot_ff] && rd_task_ff == task_ff && !hit_ff) begin
               hit_in      = 1'b1;
               hit_slot_in = rd_slot_ff;
            end
            if (rd_v_ff && !valid_ff[rd_slot_ff] && !free_ff) begin
               free_in      = 1'b1;
               free_slot_in = rd_slot_ff;
            end
            if (idx_ff < CNT_W'(SLOTS)) begin
               rd_v_in    = 1'b1;
               rd_slot_in = idx_s;
               idx_in     = idx_ff + 1'b1;
            end else if (!rd_v_ff) begin
               idx_in   = CNT_W'(hit_slot_ff);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // rd_* holds the hit slot once the read has been issued
            if (!rd_v_ff) begin
               rd_v_in = 1'b1;
            end else if (oreg_empty) begin
               push_data_in = '{status: ST_OK, task_id: '0, cpu_id: '0,
                                prio: '0, last: 1'b1};
               cur_cpu_in   = '0;
               rank_in      = '0;
               done_in      = '0;
               any_in       = 1'b0;
               idx_in       = '0;
               best_ok_in   = 1'b0;
               state_in     = S_SCAN;
               if (kind_ff == KIND_ADD) begin
                  if (bad_cpu) begin
                     push_data_in.status = ST_BAD_CPU;
                     push_in = 1'b1; state_in = S_IDLE;
                  end else if (bad_times) begin
                     push_data_in.status = ST_BAD_TIMES;
                     push_in = 1'b1; state_in = S_IDLE;
                  end else if (hit_ff) begin
                     push_data_in.status = ST_PRESENT;
                     push_in = 1'b1; state_in = S_IDLE;
                  end else if (!free_ff) begin
                     push_data_in.status = ST_FULL;
                     push_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     mem_we_in = 1'b1; wr_all_in = 1'b1;
                     mem_wa_in = free_slot_ff; wr_abs_in = sum;
                     valid_in[free_slot_ff] = 1'b1;
                  end
               end else if (!hit_ff) begin
                  push_data_in.status = ST_NOT_FOUND;
                  push_in = 1'b1; state_in = S_IDLE;
               end else if (kind_ff == KIND_REMOVE) begin
                  valid_in[hit_slot_ff] = 1'b0;
               end else begin
                  mem_we_in = 1'b1; mem_wa_in = hit_slot_ff; wr_abs_in = sum;
               end
            end
         end
         S_SCAN: begin
            // sweep slots for the earliest not-yet-emitted one on cur cpu
            if (rd_v_ff && valid_ff[rd_slot_ff] && !done_ff[rd_slot_ff]
                && rd_cpu_ff == cur_cpu_ff && (!best_ok_ff || lt)) begin
               best_ok_in  = 1'b1;
               best_in     = rd_slot_ff;
               best_abs_in = rd_abs_ff;
            end
            if (idx_ff < CNT_W'(SLOTS) && !mem_we_ff) begin
               rd_v_in    = 1'b1;
               rd_slot_in = idx_s;
               idx_in     = idx_ff + 1'b1;
            end else if (!rd_v_ff && !mem_we_ff) begin
               idx_in   = CNT_W'(best_ff);
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (!best_ok_ff) begin
               // cpu exhausted
               rank_in = '0;
               idx_in  = '0;
               if (cur_cpu_ff == CPU_W'(CPU_COUNT - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  cur_cpu_in = cur_cpu_ff + 1'b1;
                  state_in   = S_SCAN;
               end
            end else if (!rd_v_ff) begin
               rd_v_in = 1'b1;   // read best slot's task
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold the previous result back until the next is known,
            // so the last mark can be set
            if (oreg_empty) begin
               if (best_ok_ff) begin
                  if (any_ff) begin
                     push_in      = 1'b1;
                     push_data_in = pend_ff;
                  end
                  pend_in = '{status: ST_OK, task_id: rd_task_ff,
                              cpu_id: cur_cpu_ff, prio: prio_val, last: 1'b0};
                  any_in           = 1'b1;
                  done_in[best_ff] = 1'b1;
                  rank_in          = rank_ff + 1'b1;
                  best_ok_in       = 1'b0;
                  idx_in           = '0;
                  state_in         = S_SCAN;
               end else begin
                  push_in = 1'b1;
                  if (any_ff) begin
                     push_data_in      = pend_ff;
                     push_data_in.last = 1'b1;
                  end else begin
                     push_data_in = '{status: ST_EMPTY, task_id: '0, cpu_id: '0,
                                      prio: '0, last: 1'b1};
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         num_cpus_ff <= 5'd4;
         top_ff      <= 7'd99;
         push_ff     <= 1'b0;
         mem_we_ff   <= 1'b0;
         rd_v_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         num_cpus_ff <= num_cpus_in;
         top_ff      <= top_in;
         push_ff     <= push_in;
         mem_we_ff   <= mem_we_in;
         rd_v_ff     <= rd_v_in;
      end
      kind_ff      <= kind_in;
      task_ff      <= task_in;
      cpu_ff       <= cpu_in;
      budget_ff    <= budget_in;
      dl_ff        <= dl_in;
      now_ff       <= now_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      cur_cpu_ff   <= cur_cpu_in;
      rank_ff      <= rank_in;
      done_ff      <= done_in;
      best_ok_ff   <= best_ok_in;
      best_ff      <= best_in;
      best_abs_ff  <= best_abs_in;
      any_ff       <= any_in;
      pend_ff      <= pend_in;
      rd_slot_ff   <= rd_slot_in;
      mem_wa_ff    <= mem_wa_in;
      wr_all_ff    <= wr_all_in;
      wr_abs_ff    <= wr_abs_in;
      push_data_ff <= push_data_in;
   end

endmodule

// File: src/edf_out_reg.sv
// Output register: push a result only when empty, not enforced; holds it while stalled.
module edf_out_reg
   import edf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       empty,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   // free when empty or draining this cycle
   assign empty     = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: src/edf_checker.sv
module edf_checker
   import edf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic       rsp_last,
   input logic [TASK_W-1:0] rsp_out_task_id
);

   // errors are single results
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error result without last");

   // error results carry no task
   a_err_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK && rsp_status != ST_EMPTY
      |-> rsp_out_task_id == '0)
      else $error("error result with task");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   // no result code beyond the defined ones
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_EMPTY)
      else $error("bad status");

   // more results to come: the block is still busy with the event
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("idle before last result");

endmodule

bind edf_partitioned_priority_table edf_checker u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_last, .rsp_out_task_id
);

// File: bench/edf_checker.sv
`timescale 1ns / 1ps

// Watches the event, result and register channels of the EDF priority table,
// keeps its own copy of the reservation table and checks every result transfer.
module edf_scoreboard
   import edf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [TASK_W-1:0] req_task_id,
   input  logic [7:0]        req_cpu_id,
   input  logic [TIME_W-1:0] req_budget_ns,
   input  logic [TIME_W-1:0] req_deadline_ns,
   input  logic [TIME_W-1:0] req_now_ns,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [2:0]        rsp_status,
   input  logic [TASK_W-1:0] rsp_out_task_id,
   input  logic [CPU_W-1:0]  rsp_out_cpu_id,
   input  logic [PRIO_W-1:0] rsp_priority_res,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata,
   output int                fail_count,
   output int                pending,
   output int                event_count,
   output int                result_count,
   output int                full_count,
   output int                empty_count
);

   // shadow reservation table and registers
   logic              shadow_used [SLOTS];
   logic [TASK_W-1:0] shadow_task [SLOTS];
   logic [CPU_W-1:0]  shadow_cpu  [SLOTS];
   logic [TIME_W-1:0] shadow_rel  [SLOTS];
   logic [TIME_W-1:0] shadow_abs  [SLOTS];
   logic [4:0]        cpu_limit;
   logic [6:0]        top_prio;
   result_type        expected_q[$];

   function automatic int find_slot(logic [TASK_W-1:0] tid);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_used[i] && shadow_task[i] == tid) return i;
      return -1;
   endfunction

   task automatic push_status(logic [2:0] st);
      result_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      expected_q.push_back(r);
      if (st == ST_FULL) full_count++;
      if (st == ST_EMPTY) empty_count++;
   endtask

   // rank each cpu's tasks by absolute deadline, ties to the lower slot
   task automatic push_priorities();
      int rank [SLOTS];
      int n;
      result_type r;
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
         rank[i] = 0;
         if (shadow_used[i])
            for (int j = 0; j < SLOTS; j++)
               if (j != i && shadow_used[j] && shadow_cpu[j] == shadow_cpu[i] &&
                   (shadow_abs[j] < shadow_abs[i] ||
                    (shadow_abs[j] == shadow_abs[i] && j < i)))
                  rank[i]++;
      end
      for (int c = 0; c < CPU_COUNT; c++)
         for (int rk = 0; rk < SLOTS; rk++)
            for (int i = 0; i < SLOTS; i++)
               if (shadow_used[i] && shadow_cpu[i] == c && rank[i] == rk) begin
                  r = '0;
                  r.status = ST_OK;
                  r.task_id = shadow_task[i];
                  r.cpu_id = CPU_W'(c);
                  r.prio = (top_prio >= rk) ? PRIO_W'(top_prio - rk) : '0;
                  expected_q.push_back(r);
                  n++;
               end
      if (n == 0) push_status(ST_EMPTY);
      else expected_q[$].last = 1'b1;
   endtask

   task automatic predict_event();
      int s;
      int ncpu;
      event_count++;
      ncpu = (cpu_limit > CPU_COUNT) ? CPU_COUNT : cpu_limit;
      if (req_kind == KIND_ADD) begin
         s = -1;
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!shadow_used[i]) s = i;
         if (req_cpu_id >= ncpu) push_status(ST_BAD_CPU);
         else if (req_budget_ns == 0 || req_deadline_ns == 0 ||
                  req_deadline_ns < req_budget_ns) push_status(ST_BAD_TIMES);
         else if (find_slot(req_task_id) >= 0) push_status(ST_PRESENT);
         else if (s < 0) push_status(ST_FULL);
         else begin
            shadow_used[s] = 1'b1;
            shadow_task[s] = req_task_id;
            shadow_cpu[s] = req_cpu_id[CPU_W-1:0];
            shadow_rel[s] = req_deadline_ns;
            shadow_abs[s] = req_now_ns + req_deadline_ns;
            push_priorities();
         end
      end else if (req_kind == KIND_REMOVE || req_kind == KIND_EXPIRE) begin
         s = find_slot(req_task_id);
         if (s < 0) push_status(ST_NOT_FOUND);
         else begin
            if (req_kind == KIND_REMOVE) shadow_used[s] = 1'b0;
            else shadow_abs[s] = req_now_ns + shadow_rel[s];
            push_priorities();
         end
      end
      // unused kind: nothing comes back
   endtask

   task automatic check_result();
      result_type want;
      result_count++;
      if (expected_q.size() == 0) begin
         $error("result transfer with nothing expected: status %0d", rsp_status);
         fail_count++;
         return;
      end
      want = expected_q.pop_front();
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_status);
         fail_count++;
      end
      if (rsp_out_task_id !== want.task_id) begin
         $error("out_task_id: expected %0h, got %0h", want.task_id, rsp_out_task_id);
         fail_count++;
      end
      if (rsp_out_cpu_id !== want.cpu_id) begin
         $error("out_cpu_id: expected %0d, got %0d", want.cpu_id, rsp_out_cpu_id);
         fail_count++;
      end
      if (rsp_priority_res !== want.prio) begin
         $error("priority_res: expected %0d, got %0d", want.prio, rsp_priority_res);
         fail_count++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_last);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      event_count = 0;
      result_count = 0;
      full_count = 0;
      empty_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
         cpu_limit = 5'd4;
         top_prio = 7'd99;
         expected_q.delete();
      end else begin
         // results first: they belong to events already predicted
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_CPUS) cpu_limit = csr_wdata[4:0];
            else top_prio = csr_wdata;
         end
         if (req_valid && !req_stall) predict_event();
      end
      pending = expected_q.size();
   end

endmodule

// File: bench/tb_edf_partitioned_priority_table.sv
`timescale 1ns / 1ps

module tb_edf_partitioned_priority_table;
   import edf_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_kind = '0;
   logic [TASK_W-1:0] req_task_id = '0;
   logic [7:0]        req_cpu_id = '0;
   logic [TIME_W-1:0] req_budget_ns = '0;
   logic [TIME_W-1:0] req_deadline_ns = '0;
   logic [TIME_W-1:0] req_now_ns = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic [TASK_W-1:0] rsp_out_task_id;
   logic [CPU_W-1:0]  rsp_out_cpu_id;
   logic [PRIO_W-1:0] rsp_priority_res;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = 1'b0;
   logic [6:0]        csr_wdata = '0;

   int fail_count, pending, event_count, result_count, full_count, empty_count;
   logic              long_hold = 1'b0;
   logic [TASK_W-1:0] id_pool [48];
   logic [4:0]        cur_cpus;

   localparam int SETTLE_CYCLES = 2000;

   always #5 clock = ~clock;

   edf_partitioned_priority_table i_dut (.*);

   edf_scoreboard i_checker (.*);

   // runaway guard
   initial begin
      #30ms;
      $display("tb_edf_partitioned_priority_table: done, errors");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            for (int k = 0; k < 600; k++) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            rsp_stall = 1'b1;
            for (int k = 1; k < gap; k++) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic idle_gap();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: n = $urandom_range(1, 3);
         3:       n = $urandom_range(20, 80);
         default: n = 0;
      endcase
      repeat (n) @(negedge clock);
   endtask

   // one event transfer; valid stays up until the block takes it
   task automatic send_event(logic [1:0] kind, logic [TASK_W-1:0] tid, logic [7:0] cpu,
                             logic [63:0] budget, logic [63:0] dl, logic [63:0] now);
      req_valid = 1'b1;
      req_kind = kind;
      req_task_id = tid;
      req_cpu_id = cpu;
      req_budget_ns = budget;
      req_deadline_ns = dl;
      req_now_ns = now;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      idle_gap();
   endtask

   task automatic write_reg(logic idx, logic [6:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_NUM_CPUS) cur_cpus = data[4:0];
   endtask

   // drain all expected results, then let any result-free event finish
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_event();
      logic [1:0]        kind;
      logic [TASK_W-1:0] tid;
      logic [7:0]        cpu;
      logic [63:0]       budget, dl, now;
      int                pick;
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? KIND_ADD : (pick < 72) ? KIND_REMOVE :
             (pick < 96) ? KIND_EXPIRE : KIND_UNUSED;
      tid = ($urandom_range(0, 9) == 0) ? TASK_W'($urandom) : id_pool[$urandom_range(0, 47)];
      if ($urandom_range(0, 9) == 0) cpu = 8'($urandom);
      else cpu = 8'($urandom_range(0, (cur_cpus > 16) ? 15 :
                                      (cur_cpus == 0 ? 0 : cur_cpus - 1)));
      case ($urandom_range(0, 9))
         0: begin budget = {$urandom, $urandom}; dl = {$urandom, $urandom}; end
         1: begin budget = 64'($urandom_range(0, 1)); dl = 64'($urandom_range(0, 1)); end
         default: begin
            budget = 64'($urandom_range(1, 5000));
            dl = budget + 64'($urandom_range(0, 20000));
         end
      endcase
      // small times often, so deadlines tie; full range for wrap-around
      case ($urandom_range(0, 3))
         0: now = {$urandom, $urandom};
         1: now = 64'd0;
         default: now = 64'($urandom_range(0, 100000));
      endcase
      send_event(kind, tid, cpu, budget, dl, now);
   endtask

   initial begin
      logic [6:0] phase_cpus [4];
      logic [6:0] phase_top  [4];
      phase_cpus = '{7'd16, 7'd1, 7'h7F, 7'd2};
      phase_top  = '{7'd127, 7'd31, 7'h7F, 7'd3};
      cur_cpus = 5'd4;
      for (int i = 0; i < 48; i++) id_pool[i] = TASK_W'($urandom);
      id_pool[0] = '0;
      id_pool[1] = '1;

      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: error paths, extremes, wrap-around and ties, at reset settings
      send_event(KIND_REMOVE, 22'd7, 8'd0, 64'd1, 64'd1, 64'd0);
      send_event(KIND_EXPIRE, '1, 8'd0, 64'd1, 64'd1, 64'd0);
      send_event(KIND_ADD, 22'd1, 8'd4, 64'd1, 64'd1, 64'd0);
      send_event(KIND_ADD, 22'd1, 8'hFF, 64'd1, 64'd1, 64'd0);
      send_event(KIND_ADD, 22'd1, 8'd0, 64'd0, 64'd5, 64'd0);
      send_event(KIND_ADD, 22'd1, 8'd0, 64'd5, 64'd0, 64'd0);
      send_event(KIND_ADD, 22'd1, 8'd0, 64'd6, 64'd5, 64'd0);
      send_event(KIND_ADD, 22'd0, 8'd0, '1, '1, 64'd1);
      send_event(KIND_ADD, '1, 8'd3, 64'd1, 64'd1, '1);
      send_event(KIND_ADD, '1, 8'd1, 64'd1, 64'd1, 64'd0);
      send_event(KIND_ADD, 22'd5, 8'd0, 64'd1, 64'd1, '1);
      send_event(KIND_ADD, 22'd6, 8'd0, 64'd2, 64'd9, 64'd0);
      send_event(KIND_EXPIRE, 22'd0, 8'd0, 64'd0, 64'd0, 64'd5);
      send_event(KIND_UNUSED, 22'd5, 8'd0, 64'd1, 64'd1, 64'd0);
      send_event(KIND_REMOVE, 22'd0, 8'd0, 64'd0, 64'd0, 64'd0);
      send_event(KIND_REMOVE, 22'd5, 8'd0, 64'd0, 64'd0, 64'd0);
      send_event(KIND_REMOVE, 22'd6, 8'd0, 64'd0, 64'd0, 64'd0);
      send_event(KIND_REMOVE, '1, 8'd0, 64'd0, 64'd0, 64'd0);

      // random phases at several register settings
      for (int p = 0; p < 4; p++) begin
         settle();
         write_reg(CSR_NUM_CPUS, phase_cpus[p]);
         write_reg(CSR_TOP_PRIO, phase_top[p]);
         for (int n = 0; n < 20; n++) begin
            if (p == 1 && n == 5) long_hold = 1'b1;
            random_event();
         end
      end

      settle();
      $display("covered %0d events, %0d results checked, %0d full-table and %0d empty-table",
               event_count, result_count, full_count, empty_count);
      $display("cases, over four register settings plus the reset setting");
      if (fail_count == 0)
         $display("tb_edf_partitioned_priority_table: done, clean");
      else
         $display("tb_edf_partitioned_priority_table: done, errors");
      $finish;
   end

endmodule

// File: files.f
src/edf_pkg.sv
src/edf_out_reg.sv
src/edf_partitioned_priority_table.sv
src/edf_checker.sv
bench/edf_checker.sv
bench/tb_edf_partitioned_priority_table.sv
